### hw/rtl/assert_macros.svh
// Assertion macros used by the engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DOLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define DOLE_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("forbidden condition");
`else
`define DOLE_ASSERT(lbl, clk, rstn, prop)
`define DOLE_NEVER(lbl, clk, rstn, prop)
`endif
`endif

### hw/rtl/dole_pkg.sv
// Types and codes shared by the dual ordered list engine
package dole_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic rm;
    logic rd;
    logic found;
  } tok_t;

endpackage

### hw/rtl/dole_cell.sv
// One list slot: holds an entry, shifts on insert or delete, forwards the scan token
module dole_cell import dole_pkg::*; #(
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned CNT_W       = 9,
  parameter int unsigned INDEX       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   ins_en_i,
  input  logic [CNT_W-1:0]       ins_pos_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  input  logic [CNT_W-1:0]       rd_idx_i,
  input  logic [HANDLE_BITS-1:0] left_i,
  input  logic [HANDLE_BITS-1:0] right_i,
  input  tok_t                   tok_i,
  input  logic [HANDLE_BITS-1:0] tok_data_i,
  output logic [HANDLE_BITS-1:0] entry_o,
  output tok_t                   tok_o,
  output logic [HANDLE_BITS-1:0] tok_data_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  logic [HANDLE_BITS-1:0] entry_q, entry_d;
  logic [HANDLE_BITS-1:0] data_q, data_d;
  tok_t                   tok_q, tok_d;
  logic                   in_range, match, found, shift, rd_hit;

  // Compare against the token as it passes
  assign in_range = MyIdx < count_i;
  assign match    = tok_i.valid & tok_i.rm & in_range & ~tok_i.found & (entry_q == handle_i);
  assign found    = tok_i.found | match;
  assign shift    = tok_i.valid & tok_i.rm & found & in_range;
  assign rd_hit   = tok_i.valid & tok_i.rd & (MyIdx == rd_idx_i);

  // Pick the next entry: insert shifts up, delete pulls from the right
  always_comb begin
    entry_d = entry_q;
    if (ins_en_i) begin
      if (MyIdx == ins_pos_i) begin
        entry_d = handle_i;
      end else if ((MyIdx > ins_pos_i) && (MyIdx <= count_i)) begin
        entry_d = left_i;
      end
    end else if (shift) begin
      entry_d = right_i;
    end
  end

  // Advance the token and carry read data along
  always_comb begin
    tok_d       = tok_i;
    tok_d.found = tok_i.valid & found;
    data_d      = rd_hit ? entry_q : tok_data_i;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    data_q  <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign entry_o    = entry_q;
  assign tok_o      = tok_q;
  assign tok_data_o = data_q;

endmodule

### hw/rtl/dole_chain.sv
// Row of list cells forming one ordered list
module dole_chain import dole_pkg::*; #(
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned CNT_W       = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   ins_en_i,
  input  logic [CNT_W-1:0]       ins_pos_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  input  logic [CNT_W-1:0]       rd_idx_i,
  input  tok_t                   tok_i,
  output logic [HANDLE_BITS-1:0] head_o,
  output tok_t                   tok_o,
  output logic [HANDLE_BITS-1:0] tok_data_o
);

  logic [HANDLE_BITS-1:0] entry [ENTRIES];
  tok_t                   tok   [ENTRIES+1];
  logic [HANDLE_BITS-1:0] data  [ENTRIES+1];

  assign tok[0]  = tok_i;
  assign data[0] = '0;

  // Build the row; the ends see zero neighbors
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entry[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entry[i+1];
    end

    dole_cell #(
      .HANDLE_BITS(HANDLE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_en_i  (ins_en_i),
      .ins_pos_i (ins_pos_i),
      .count_i   (count_i),
      .handle_i  (handle_i),
      .rd_idx_i  (rd_idx_i),
      .left_i    (left),
      .right_i   (right),
      .tok_i     (tok[i]),
      .tok_data_i(data[i]),
      .entry_o   (entry[i]),
      .tok_o     (tok[i+1]),
      .tok_data_o(data[i+1])
    );
  end

  assign head_o     = entry[0];
  assign tok_o      = tok[ENTRIES];
  assign tok_data_o = data[ENTRIES];

endmodule

### hw/rtl/dual_ordered_list_engine_unit.sv
// Top level of the dual ordered list engine: command port, counts and scan control
//
// Two ordered handle lists (render and click), each a row of ENTRIES cells. An
// insert, an opcode without meaning and a remove of the null handle finish at
// once: the result strobes on done in the cycle after the transfer and busy
// stays low, so these commands can be issued every cycle. A remove or a read
// sends a token down the cell rows, one cell per cycle; busy stays high until the
// token leaves the last cell, and done strobes as busy falls. Done is high for
// exactly one cycle and cannot be held off; count_out_o and head_out_o report
// the list picked by list_select_i of the last accepted command.
`include "assert_macros.svh"
module dual_ordered_list_engine_unit import dole_pkg::*; #(
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned HANDLE_BITS = 16,
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             opcode_i,
  input  logic                   list_select_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  input  logic signed [10:0]     position_i,
  output logic                   done,
  output logic [HANDLE_BITS-1:0] entry_out_o,
  output logic [CNT_W-1:0]       count_out_o,
  output logic [HANDLE_BITS-1:0] head_out_o,
  output logic [1:0]             status_o,
  output logic                   removed_render_o,
  output logic                   removed_click_o
);

  localparam int unsigned PW = ((CNT_W > 11) ? CNT_W : 11) + 1;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(ENTRIES);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       render_cnt_q, render_cnt_d, click_cnt_q, click_cnt_d;
  logic                   done_q, done_d;
  logic                   sel_q, sel_d;
  logic                   rd_ok_q, rd_ok_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic [HANDLE_BITS-1:0] entry_q, entry_d;
  status_e                status_q, status_d;
  logic                   rr_q, rr_d, rc_q, rc_d;
  tok_t                   tok_q, tok_d;

  logic                   accept;
  op_e                    op;
  logic [CNT_W-1:0]       cnt_sel;
  logic signed [PW-1:0]   pos_ext, n_ext;
  logic [CNT_W-1:0]       ins_pos;
  logic                   ins_go, r_ins, c_ins;
  tok_t                   r_tok_out, c_tok_out;
  logic [HANDLE_BITS-1:0] r_data, c_data, r_head, c_head;

  assign accept  = start & ~busy;
  assign op      = op_e'(opcode_i);
  assign cnt_sel = list_select_i ? click_cnt_q : render_cnt_q;

  // Clamp the insert position and range-check the read index
  assign pos_ext = PW'(position_i);
  assign n_ext   = signed'(PW'(cnt_sel));
  always_comb begin
    if (pos_ext[PW-1]) begin
      ins_pos = '0;
    end else if (pos_ext > n_ext) begin
      ins_pos = cnt_sel;
    end else begin
      ins_pos = CNT_W'(pos_ext);
    end
  end

  assign ins_go = accept & (op == OP_INSERT) & (cnt_sel < CntMax);
  assign r_ins  = ins_go & ~list_select_i;
  assign c_ins  = ins_go & list_select_i;

  // Command control: take commands, launch scans, retire tokens
  always_comb begin
    state_d      = state_q;
    render_cnt_d = render_cnt_q;
    click_cnt_d  = click_cnt_q;
    done_d       = 1'b0;
    sel_d        = sel_q;
    rd_ok_d      = rd_ok_q;
    handle_d     = handle_q;
    rd_idx_d     = rd_idx_q;
    entry_d      = entry_q;
    status_d     = status_q;
    rr_d         = rr_q;
    rc_d         = rc_q;
    tok_d        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sel_d    = list_select_i;
          handle_d = handle_i;
          rd_idx_d = CNT_W'(pos_ext);
          rd_ok_d  = ~pos_ext[PW-1] & (pos_ext < n_ext);
          entry_d  = '0;
          status_d = ST_DONE;
          rr_d     = 1'b0;
          rc_d     = 1'b0;
          case (op)
            OP_INSERT: begin
              done_d = 1'b1;
              if (!ins_go) begin
                status_d = ST_FULL;
              end else if (list_select_i) begin
                click_cnt_d = click_cnt_q + 1'b1;
              end else begin
                render_cnt_d = render_cnt_q + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (handle_i == '0) begin
                done_d = 1'b1;
              end else begin
                tok_d.valid = 1'b1;
                tok_d.rm    = 1'b1;
                state_d     = S_SCAN;
              end
            end
            OP_READ: begin
              tok_d.valid = 1'b1;
              tok_d.rd    = 1'b1;
              state_d     = S_SCAN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (r_tok_out.valid) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (r_tok_out.rd) begin
            entry_d = rd_ok_q ? (sel_q ? c_data : r_data) : '0;
          end else begin
            rr_d = r_tok_out.found;
            rc_d = c_tok_out.found;
            if (r_tok_out.found) begin
              render_cnt_d = render_cnt_q - 1'b1;
            end
            if (c_tok_out.found) begin
              click_cnt_d = click_cnt_q - 1'b1;
            end
            if (!r_tok_out.found && !c_tok_out.found) begin
              status_d = ST_MISS;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      render_cnt_q <= '0;
      click_cnt_q  <= '0;
      done_q       <= 1'b0;
      tok_q        <= '0;
    end else begin
      state_q      <= state_d;
      render_cnt_q <= render_cnt_d;
      click_cnt_q  <= click_cnt_d;
      done_q       <= done_d;
      tok_q        <= tok_d;
    end
  end

  // Hold command fields and result payload
  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    rd_ok_q  <= rd_ok_d;
    handle_q <= handle_d;
    rd_idx_q <= rd_idx_d;
    entry_q  <= entry_d;
    status_q <= status_d;
    rr_q     <= rr_d;
    rc_q     <= rc_d;
  end

  // Render list row
  dole_chain #(
    .ENTRIES    (ENTRIES),
    .HANDLE_BITS(HANDLE_BITS),
    .CNT_W      (CNT_W)
  ) u_render (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_en_i  (r_ins),
    .ins_pos_i (ins_pos),
    .count_i   (render_cnt_q),
    .handle_i  (r_ins ? handle_i : handle_q),
    .rd_idx_i  (rd_idx_q),
    .tok_i     (tok_q),
    .head_o    (r_head),
    .tok_o     (r_tok_out),
    .tok_data_o(r_data)
  );

  // Click list row
  dole_chain #(
    .ENTRIES    (ENTRIES),
    .HANDLE_BITS(HANDLE_BITS),
    .CNT_W      (CNT_W)
  ) u_click (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_en_i  (c_ins),
    .ins_pos_i (ins_pos),
    .count_i   (click_cnt_q),
    .handle_i  (c_ins ? handle_i : handle_q),
    .rd_idx_i  (rd_idx_q),
    .tok_i     (tok_q),
    .head_o    (c_head),
    .tok_o     (c_tok_out),
    .tok_data_o(c_data)
  );

  // Drive the result ports
  assign busy             = (state_q == S_SCAN);
  assign done             = done_q;
  assign entry_out_o      = entry_q;
  assign count_out_o      = sel_q ? click_cnt_q : render_cnt_q;
  assign head_out_o       = (count_out_o == '0) ? '0 : (sel_q ? c_head : r_head);
  assign status_o         = status_q;
  assign removed_render_o = rr_q;
  assign removed_click_o  = rc_q;

  `DOLE_ASSERT(a_done_idle, clk_i, rst_ni, done |-> !busy)
  `DOLE_NEVER(a_cnt_bound, clk_i, rst_ni, (render_cnt_q > CntMax) || (click_cnt_q > CntMax))
  `DOLE_ASSERT(a_exit_in_scan, clk_i, rst_ni, r_tok_out.valid |-> (state_q == S_SCAN))
  `DOLE_ASSERT(a_rows_lockstep, clk_i, rst_ni, r_tok_out.valid == c_tok_out.valid)

endmodule
